[rtl/rrip_pkg.sv]
// Shared types and constants of the RRIP/SHiP replacement block.
`default_nettype none
package rrip_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_SWEEP_INTERVAL   = 2'd0;
  localparam logic [1:0] REG_STREAM_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_DEAD_THRESHOLD   = 2'd2;
  localparam logic [1:0] REG_REUSE_THRESHOLD  = 2'd3;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned CNT_W      = 20;
  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned MASK_W     = 16;

  localparam logic [CNT_W-1:0] SWEEP_INTERVAL_RST = 20'd100000;
  localparam logic [1:0]       THRESH_RST         = 2'd2;

  localparam logic [1:0]  RRPV_MAX      = 2'd3;
  localparam logic [1:0]  CTR_MAX       = 2'd3;
  localparam logic [1:0]  REUSE_RST     = 2'd1;
  localparam logic [1:0]  INS_NEAR      = 2'd0;
  localparam logic [1:0]  INS_LONG      = 2'd2;
  localparam logic [ADDR_W:0] STRIDE_1  = 49'd64;
  localparam logic [ADDR_W:0] STRIDE_2  = 49'd128;

  localparam logic FUNC_VICTIM = 1'b0;
  localparam logic FUNC_UPDATE = 1'b1;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_RD1   = 7'b0000010,
    ST_RD2   = 7'b0000100,
    ST_RD3   = 7'b0001000,
    ST_DONE  = 7'b0010000,
    ST_SWEEP = 7'b0100000,
    ST_CLEAR = 7'b1000000
  } state_t;

endpackage
`default_nettype wire

[rtl/rrip_ship_dead_stream_replacement.sv]
// Top level of the SRRIP replacement policy with signature reuse, dead-line and stream bypass.
`default_nettype none
// Replacement engine for a set-associative last-level cache. Each input word is either a
// victim request (func 0) or a replacement state update (func 1); each produces exactly one
// result word. Per-line state (re-reference value, dead counter, signature) lives in one
// line memory with one row per set; per-set stream state (last address, stride score) lives
// in a set memory; the signature reuse counters live in a small reuse memory. All memories
// are synchronous with a registered read. A victim request reads the set row at accept,
// then picks and ages in RD1, then loads the output register from DONE; an update reads the
// rows at accept, reads the reuse counter of the trained signature in RD1, writes it back
// and reads the counter of the new signature in RD2, writes back the line in RD3, then loads
// the output register from DONE. in_ready rises together with out_valid unless a sweep
// follows, so the next word is taken only once the last result is loaded; a result still held
// in the output register stalls the next word until it is taken. One word is in flight at a
// time. Every sweep_interval updates a decay sweep walks the line and reuse memories one row
// a cycle, taking no input. After reset a clearing pass initializes all memories before the
// first input word is taken; configuration writes are taken at any time.
module rrip_ship_dead_stream_replacement #(
  parameter int unsigned NUM_SETS = 2048,
  parameter int unsigned NUM_WAYS = 16,
  parameter int unsigned SIG_BITS = 6
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        func,
  input  wire logic [10:0] set_index,
  input  wire logic [3:0]  way,
  input  wire logic [15:0] valid_mask,
  input  wire logic [47:0] paddr,
  input  wire logic [7:0]  pc,
  input  wire logic        hit,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       victim_way,
  output logic [1:0]       insert_rrpv,
  output logic             bypass,
  output logic             streaming,
  input  wire logic        cfg_we,
  input  wire logic [rrip_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rrip_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned SW      = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned WW      = $clog2(NUM_WAYS);
  localparam int unsigned SIG_N   = 1 << SIG_BITS;
  localparam int unsigned RRW     = 2 * NUM_WAYS;
  localparam int unsigned LW      = NUM_WAYS * (4 + SIG_BITS);
  localparam int unsigned PASS    = (NUM_SETS > SIG_N) ? NUM_SETS : SIG_N;
  localparam int unsigned CW      = $clog2(PASS + 1);
  localparam int unsigned AW      = rrip_pkg::ADDR_W;
  localparam int unsigned SETW    = AW + 2;

  // Memories
  logic [LW-1:0]   line_mem  [NUM_SETS];
  logic [SETW-1:0] set_mem   [NUM_SETS];
  logic [1:0]      reuse_mem [SIG_N];

  logic [LW-1:0]   line_q;
  logic [SETW-1:0] set_q;
  logic [1:0]      reuse_q;

  // Configuration
  logic [rrip_pkg::CNT_W-1:0] sweep_interval;
  logic [1:0] stream_threshold, dead_threshold, reuse_threshold;
  logic [rrip_pkg::CNT_W-1:0] update_count, update_count_next;

  rrip_pkg::state_t state;

  // Held item
  logic [SW-1:0]       s_q;
  logic [WW-1:0]       w_q;
  logic [SIG_BITS-1:0] sig_q, x_q;
  logic                hit_q, func_q;
  logic [15:0]         mask_q;
  logic [AW-1:0]       addr_q;
  logic [1:0]          dead_new_q, r_new_q;
  logic                str_q, sweep_pend;
  logic [CW-1:0]       cnt;

  // Results waiting for the output register
  logic [3:0] res_victim;
  logic [1:0] res_ins;
  logic       res_byp, res_str;

  function automatic logic [SW-1:0] set_mod(input logic [10:0] v);
    logic [27:0] r;
    r = 28'(v);
    for (int k = 10; k >= 0; k--) begin
      if (r >= (28'(NUM_SETS) << k)) r = r - (28'(NUM_SETS) << k);
    end
    return SW'(r);
  endfunction

  function automatic logic [WW-1:0] way_mod(input logic [3:0] v);
    logic [9:0] r;
    r = 10'(v);
    for (int k = 3; k >= 0; k--) begin
      if (r >= (10'(NUM_WAYS) << k)) r = r - (10'(NUM_WAYS) << k);
    end
    return WW'(r);
  endfunction

  logic accept;
  logic out_load;
  logic [SW-1:0] s_in;
  assign in_ready = (state == rrip_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign s_in     = set_mod(set_index);
  // Load the output register once the previous word is gone or leaves this cycle
  assign out_load = (state == rrip_pkg::ST_DONE) && (!out_valid || out_ready);

  // Victim pick and aging over the set row
  logic          inv_found;
  logic [WW-1:0] inv_way, top_way;
  logic [1:0]    top, add;
  logic [RRW-1:0] aged;
  logic          top_found;

  always_comb begin
    inv_found = 1'b0;
    inv_way   = '0;
    top       = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (w < 16 && !mask_q[w % 16]) begin
        inv_found = 1'b1;
        inv_way   = WW'(w);
      end
    end
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (line_q[2*w +: 2] > top) top = line_q[2*w +: 2];
    end
    add = rrip_pkg::RRPV_MAX - top;
    for (int w = 0; w < NUM_WAYS; w++) begin
      aged[2*w +: 2] = line_q[2*w +: 2] + add;
    end
    top_found = 1'b0;
    top_way   = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (aged[2*w +: 2] == rrip_pkg::RRPV_MAX) begin
        top_found = 1'b1;
        top_way   = WW'(w);
      end
    end
  end

  // Stream detector and dead counter, from the rows read at accept
  logic [AW-1:0] last;
  logic [1:0]    score, score_new, dead_old, dead_new;
  logic [AW:0]   diff, delta;
  logic          str_now;
  logic [SIG_BITS-1:0] old_sig, x_sel;

  always_comb begin
    last  = set_q[SETW-1 -: AW];
    score = set_q[1:0];
    diff  = {1'b0, addr_q} - {1'b0, last};
    delta = diff[AW] ? ({1'b0, last} - {1'b0, addr_q}) : diff;
    if (last == '0) begin
      score_new = '0;
    end else if (delta == rrip_pkg::STRIDE_1 || delta == rrip_pkg::STRIDE_2) begin
      score_new = (score == rrip_pkg::CTR_MAX) ? score : score + 2'd1;
    end else begin
      score_new = (score == 2'd0) ? score : score - 2'd1;
    end
    str_now  = score_new >= stream_threshold;
    dead_old = line_q[RRW + 2*w_q +: 2];
    if (hit_q) dead_new = 2'd0;
    else dead_new = (dead_old == rrip_pkg::CTR_MAX) ? dead_old : dead_old + 2'd1;
    old_sig = line_q[2*RRW + SIG_BITS*w_q +: SIG_BITS];
    x_sel   = hit_q ? sig_q : old_sig;
  end

  // Reuse counter training and insertion choice
  logic [1:0] r_new, r_sig, ins;
  logic       byp;
  always_comb begin
    if (hit_q) r_new = (reuse_q == rrip_pkg::CTR_MAX) ? reuse_q : reuse_q + 2'd1;
    else r_new = (reuse_q == 2'd0) ? reuse_q : reuse_q - 2'd1;
    r_sig = (x_q == sig_q) ? r_new_q : reuse_q;
    byp   = str_q || (dead_new_q >= dead_threshold);
    if (byp) ins = rrip_pkg::RRPV_MAX;
    else if (r_sig >= reuse_threshold) ins = rrip_pkg::INS_NEAR;
    else ins = rrip_pkg::INS_LONG;
    update_count_next = update_count + 1'b1;
  end

  // Sweep row: saturating decrement of every dead counter
  logic [CW-1:0] cnt_prev;
  logic [LW-1:0] decayed;
  always_comb begin
    cnt_prev = cnt - 1'b1;
    decayed  = line_q;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (line_q[RRW + 2*w +: 2] != 2'd0) decayed[RRW + 2*w +: 2] = line_q[RRW + 2*w +: 2] - 2'd1;
    end
  end

  // Memory port steering
  logic            lre, sre, rre, lwe, swe, rwe;
  logic [SW-1:0]   lra, lwa, swa;
  logic [SIG_BITS-1:0] rra, rwa;
  logic [LW-1:0]   lwd, upd_row, clr_row;
  logic [SETW-1:0] swd;
  logic [1:0]      rwd;

  always_comb begin
    upd_row = line_q;
    upd_row[2*w_q +: 2]                         = ins;
    upd_row[RRW + 2*w_q +: 2]                   = dead_new_q;
    upd_row[2*RRW + SIG_BITS*w_q +: SIG_BITS]   = sig_q;
    clr_row = '0;
    for (int w = 0; w < NUM_WAYS; w++) clr_row[2*w +: 2] = rrip_pkg::RRPV_MAX;
  end

  always_comb begin
    lre = 1'b0; sre = 1'b0; rre = 1'b0;
    lwe = 1'b0; swe = 1'b0; rwe = 1'b0;
    lra = s_in; lwa = s_q; swa = s_q;
    rra = x_sel; rwa = x_q;
    lwd = upd_row; swd = {addr_q, score_new}; rwd = r_new;
    unique case (state)
      rrip_pkg::ST_IDLE: begin
        lre = accept;
        sre = accept;
      end
      rrip_pkg::ST_RD1: begin
        if (func_q == rrip_pkg::FUNC_VICTIM) begin
          lwe = !inv_found && (top != rrip_pkg::RRPV_MAX);
          lwd = {line_q[LW-1:RRW], aged};
        end else begin
          swe = 1'b1;
          rre = 1'b1;
        end
      end
      rrip_pkg::ST_RD2: begin
        rwe = 1'b1;
        rre = 1'b1;
        rra = sig_q;
      end
      rrip_pkg::ST_RD3: begin
        lwe = 1'b1;
      end
      rrip_pkg::ST_DONE: begin
      end
      rrip_pkg::ST_SWEEP: begin
        lra = cnt[SW-1:0];
        rra = cnt[SIG_BITS-1:0];
        lre = 32'(cnt) < NUM_SETS;
        rre = 32'(cnt) < SIG_N;
        lwa = cnt_prev[SW-1:0];
        rwa = cnt_prev[SIG_BITS-1:0];
        lwe = (cnt != '0) && (32'(cnt_prev) < NUM_SETS);
        rwe = (cnt != '0) && (32'(cnt_prev) < SIG_N);
        lwd = decayed;
        rwd = (reuse_q == 2'd0) ? reuse_q : reuse_q - 2'd1;
      end
      rrip_pkg::ST_CLEAR: begin
        lwa = cnt[SW-1:0];
        swa = cnt[SW-1:0];
        rwa = cnt[SIG_BITS-1:0];
        lwe = 32'(cnt) < NUM_SETS;
        swe = 32'(cnt) < NUM_SETS;
        rwe = 32'(cnt) < SIG_N;
        lwd = clr_row;
        swd = '0;
        rwd = rrip_pkg::REUSE_RST;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (lwe) line_mem[lwa] <= lwd;
    if (lre) line_q <= line_mem[lra];
  end

  always_ff @(posedge clk) begin
    if (swe) set_mem[swa] <= swd;
    if (sre) set_q <= set_mem[s_in];
  end

  always_ff @(posedge clk) begin
    if (rwe) reuse_mem[rwa] <= rwd;
    if (rre) reuse_q <= reuse_mem[rra];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_interval   <= rrip_pkg::SWEEP_INTERVAL_RST;
      stream_threshold <= rrip_pkg::THRESH_RST;
      dead_threshold   <= rrip_pkg::THRESH_RST;
      reuse_threshold  <= rrip_pkg::THRESH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rrip_pkg::REG_SWEEP_INTERVAL:   sweep_interval   <= cfg_data;
        rrip_pkg::REG_STREAM_THRESHOLD: stream_threshold <= cfg_data[1:0];
        rrip_pkg::REG_DEAD_THRESHOLD:   dead_threshold   <= cfg_data[1:0];
        rrip_pkg::REG_REUSE_THRESHOLD:  reuse_threshold  <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  // Hold the accepted word
  always_ff @(posedge clk) begin
    if (accept) begin
      s_q    <= s_in;
      w_q    <= way_mod(way);
      sig_q  <= SIG_BITS'(pc[7:2]);
      hit_q  <= hit;
      func_q <= func;
      mask_q <= valid_mask;
      addr_q <= paddr;
    end
    if (state == rrip_pkg::ST_RD1) begin
      dead_new_q <= dead_new;
      str_q      <= str_now;
      x_q        <= x_sel;
    end
    if (state == rrip_pkg::ST_RD2) r_new_q <= r_new;
  end

  // Output register: load the finished word, drop valid once it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      victim_way  <= res_victim;
      insert_rrpv <= res_ins;
      bypass      <= res_byp;
      streaming   <= res_str;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rrip_pkg::ST_CLEAR;
      cnt          <= '0;
      update_count <= '0;
      sweep_pend   <= 1'b0;
    end else begin
      unique case (state)
        rrip_pkg::ST_IDLE: begin
          if (accept) state <= rrip_pkg::ST_RD1;
        end
        rrip_pkg::ST_RD1: begin
          if (func_q == rrip_pkg::FUNC_VICTIM) begin
            res_victim <= 4'(inv_found ? inv_way : (top_found ? top_way : '0));
            res_ins    <= '0;
            res_byp    <= 1'b0;
            res_str    <= 1'b0;
            state      <= rrip_pkg::ST_DONE;
          end else begin
            state <= rrip_pkg::ST_RD2;
          end
        end
        rrip_pkg::ST_RD2: state <= rrip_pkg::ST_RD3;
        rrip_pkg::ST_RD3: begin
          res_victim <= '0;
          res_ins    <= ins;
          res_byp    <= byp;
          res_str    <= str_q;
          if (update_count_next >= sweep_interval) begin
            update_count <= '0;
            sweep_pend   <= 1'b1;
          end else begin
            update_count <= update_count_next;
          end
          state <= rrip_pkg::ST_DONE;
        end
        rrip_pkg::ST_DONE: begin
          if (out_load) begin
            cnt         <= '0;
            sweep_pend  <= 1'b0;
            state       <= sweep_pend ? rrip_pkg::ST_SWEEP : rrip_pkg::ST_IDLE;
          end
        end
        rrip_pkg::ST_SWEEP: begin
          cnt <= cnt + 1'b1;
          if (32'(cnt) == PASS) state <= rrip_pkg::ST_IDLE;
        end
        rrip_pkg::ST_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (32'(cnt) == PASS - 1) state <= rrip_pkg::ST_IDLE;
        end
        default: state <= rrip_pkg::ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[test/rrip_checker.sv]
// Result checker: predicts the replacement policy and compares every result word.
module rrip_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        func,
  input  logic [10:0] set_index,
  input  logic [3:0]  way,
  input  logic [15:0] valid_mask,
  input  logic [47:0] paddr,
  input  logic [7:0]  pc,
  input  logic        hit,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  victim_way,
  input  logic [1:0]  insert_rrpv,
  input  logic        bypass,
  input  logic        streaming,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0] victim_way;
    logic [1:0] insert_rrpv;
    logic       bypass;
    logic       streaming;
  } policy_word_t;

  logic [1:0]  rrpv_mem [2048][16];
  logic [1:0]  dead_mem [2048][16];
  logic [5:0]  sig_mem  [2048][16];
  logic [1:0]  reuse_mem [64];
  logic [47:0] last_addr_mem [2048];
  logic [1:0]  score_mem [2048];
  logic [19:0] update_ctr;
  logic [19:0] period_q;
  logic [1:0]  stream_th_q, dead_th_q, reuse_th_q;
  policy_word_t expected_words [$];

  assign pending = expected_words.size();

  function automatic policy_word_t predict_word(input logic f, input logic [10:0] s,
      input logic [3:0] w, input logic [15:0] m, input logic [47:0] a, input logic [7:0] p,
      input logic h);
    policy_word_t r;
    logic [1:0] top;
    logic [5:0] sig, old_sig;
    logic [47:0] last, delta;
    logic strm, byp;
    r = '0;
    if (f == rrip_pkg::FUNC_VICTIM) begin
      for (int i = 0; i < 16; i++) begin
        if (!m[i]) begin
          r.victim_way = 4'(i);
          return r;
        end
      end
      top = 2'd0;
      for (int i = 0; i < 16; i++) if (rrpv_mem[s][i] > top) top = rrpv_mem[s][i];
      for (int i = 0; i < 16; i++) rrpv_mem[s][i] = rrpv_mem[s][i] + (2'd3 - top);
      for (int i = 15; i >= 0; i--) if (rrpv_mem[s][i] == 2'd3) r.victim_way = 4'(i);
      return r;
    end
    sig = p[7:2];
    last = last_addr_mem[s];
    if (last == 0) score_mem[s] = 2'd0;
    else begin
      delta = (a > last) ? a - last : last - a;
      if (delta == 64 || delta == 128) begin
        if (score_mem[s] < 3) score_mem[s]++;
      end else if (score_mem[s] > 0) score_mem[s]--;
    end
    last_addr_mem[s] = a;
    strm = score_mem[s] >= stream_th_q;
    old_sig = sig_mem[s][w];
    if (h) begin
      dead_mem[s][w] = 2'd0;
      if (reuse_mem[sig] < 3) reuse_mem[sig]++;
    end else begin
      if (dead_mem[s][w] < 3) dead_mem[s][w]++;
      if (reuse_mem[old_sig] > 0) reuse_mem[old_sig]--;
    end
    byp = strm || (dead_mem[s][w] >= dead_th_q);
    if (byp) r.insert_rrpv = 2'd3;
    else if (reuse_mem[sig] >= reuse_th_q) r.insert_rrpv = 2'd0;
    else r.insert_rrpv = 2'd2;
    rrpv_mem[s][w] = r.insert_rrpv;
    sig_mem[s][w] = sig;
    update_ctr = update_ctr + 20'd1;
    if (update_ctr >= period_q) begin
      update_ctr = 20'd0;
      // sweep: drop every dead and reuse counter by one, floor at zero
      for (int i = 0; i < 2048; i++)
        for (int j = 0; j < 16; j++) if (dead_mem[i][j] > 0) dead_mem[i][j]--;
      for (int i = 0; i < 64; i++) if (reuse_mem[i] > 0) reuse_mem[i]--;
    end
    r.bypass = byp;
    r.streaming = strm;
    return r;
  endfunction

  always @(posedge clk) begin
    policy_word_t got, exp_w;
    if (rst) begin
      for (int i = 0; i < 2048; i++) begin
        for (int j = 0; j < 16; j++) begin
          rrpv_mem[i][j] = 2'd3;
          dead_mem[i][j] = 2'd0;
          sig_mem[i][j] = 6'd0;
        end
        last_addr_mem[i] = 48'd0;
        score_mem[i] = 2'd0;
      end
      for (int i = 0; i < 64; i++) reuse_mem[i] = 2'd1;
      update_ctr = 20'd0;
      period_q = rrip_pkg::SWEEP_INTERVAL_RST;
      stream_th_q = rrip_pkg::THRESH_RST;
      dead_th_q = rrip_pkg::THRESH_RST;
      reuse_th_q = rrip_pkg::THRESH_RST;
      expected_words.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rrip_pkg::REG_SWEEP_INTERVAL:   period_q = cfg_data;
          rrip_pkg::REG_STREAM_THRESHOLD: stream_th_q = cfg_data[1:0];
          rrip_pkg::REG_DEAD_THRESHOLD:   dead_th_q = cfg_data[1:0];
          rrip_pkg::REG_REUSE_THRESHOLD:  reuse_th_q = cfg_data[1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = {victim_way, insert_rrpv, bypass, streaming};
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word %h", $time, got);
          fail_count++;
        end else begin
          exp_w = expected_words.pop_front();
          if (got.victim_way != exp_w.victim_way)
            $display("%0t: victim_way exp %0d got %0d", $time, exp_w.victim_way, got.victim_way);
          if (got.insert_rrpv != exp_w.insert_rrpv)
            $display("%0t: insert_rrpv exp %0d got %0d", $time, exp_w.insert_rrpv,
                     got.insert_rrpv);
          if (got.bypass != exp_w.bypass)
            $display("%0t: bypass exp %0d got %0d", $time, exp_w.bypass, got.bypass);
          if (got.streaming != exp_w.streaming)
            $display("%0t: streaming exp %0d got %0d", $time, exp_w.streaming, got.streaming);
          if (got != exp_w) fail_count++;
        end
      end
      if (in_valid && in_ready)
        expected_words.push_back(predict_word(func, set_index, way, valid_mask, paddr, pc, hit));
    end
  end
endmodule

[test/tb_top.sv]
// Testbench top: drives stimulus and configuration into the replacement block and gives the verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_CYCLES = 2200;   // longer than one decay sweep

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic func = 0, hit = 0;
  logic [10:0] set_index = 0;
  logic [3:0] way = 0, victim_way;
  logic [15:0] valid_mask = 0;
  logic [47:0] paddr = 0;
  logic [7:0] pc = 0;
  logic [1:0] insert_rrpv;
  logic bypass, streaming;
  logic cfg_we = 0;
  logic [1:0] cfg_index = 0;
  logic [19:0] cfg_data = 0;
  int fail_count, pending;
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit hold_off = 0;
  int cycle_count = 0;

  // working set of a few sets so that state builds up
  logic [10:0] hot_sets [8];
  logic [47:0] stream_addr [8];

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  rrip_ship_dead_stream_replacement DUT (.*);

  rrip_checker u_checker (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random stall, or a long hold-off while hold_off is set
  always @(negedge clk) begin
    if (rst) out_ready <= 0;
    else out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // one write, then a quiet gap so that back-to-back writes never collide
  task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // offer one word and hold it until accepted; valid drops at the next idle or at wait_idle
  task automatic send_word(input logic f, input logic [10:0] s, input logic [3:0] w,
      input logic [15:0] m, input logic [47:0] a, input logic [7:0] p, input logic h);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    func <= f; set_index <= s; way <= w; valid_mask <= m; paddr <= a; pc <= p; hit <= h;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_word();
    int k, r;
    logic [10:0] s;
    k = $urandom_range(7);
    r = $urandom_range(99);
    s = (r < 85) ? hot_sets[k] : 11'($urandom);
    if (r < 30) begin
      // victim request: mostly full sets, sometimes a hole
      send_word(rrip_pkg::FUNC_VICTIM, s, 4'($urandom),
                ($urandom_range(3) == 0) ? 16'($urandom) : 16'hFFFF,
                48'($urandom), 8'($urandom), 1'($urandom));
    end else if (r < 65) begin
      // strided stream update
      stream_addr[k] = stream_addr[k] + (($urandom_range(1)) ? 64 : 128);
      send_word(rrip_pkg::FUNC_UPDATE, s, 4'($urandom), 16'($urandom), stream_addr[k],
                8'($urandom_range(15)), 1'($urandom));
    end else begin
      send_word(rrip_pkg::FUNC_UPDATE, s, 4'($urandom), 16'($urandom),
                {16'($urandom), 32'($urandom)}, 8'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) begin
      hot_sets[i] = 11'($urandom);
      stream_addr[i] = {16'($urandom), 32'($urandom)};
    end
    repeat (3) @(negedge clk);
    rst <= 0;
    // configuration: extremes plus a short decay period
    write_reg(rrip_pkg::REG_SWEEP_INTERVAL, 20'd1);
    write_reg(rrip_pkg::REG_STREAM_THRESHOLD, 2'd3);
    write_reg(rrip_pkg::REG_DEAD_THRESHOLD, 2'd0);
    write_reg(rrip_pkg::REG_REUSE_THRESHOLD, 2'd0);

    // directed: field extremes, both functions, unseen set, stride edges
    send_word(rrip_pkg::FUNC_VICTIM, 11'd0, 4'd0, 16'h0000, 48'd0, 8'd0, 1'b0);
    send_word(rrip_pkg::FUNC_VICTIM, 11'h7FF, 4'hF, 16'hFFFF, '1, 8'hFF, 1'b1);
    send_word(rrip_pkg::FUNC_VICTIM, 11'd5, 4'd0, 16'h7FFF, 48'd0, 8'd0, 1'b0);
    send_word(rrip_pkg::FUNC_UPDATE, 11'd5, 4'd0, 16'd0, 48'h1000, 8'hFC, 1'b0);
    send_word(rrip_pkg::FUNC_UPDATE, 11'd5, 4'hF, 16'd0, 48'h1040, 8'hFC, 1'b1);
    send_word(rrip_pkg::FUNC_UPDATE, 11'd5, 4'd3, 16'd0, 48'h10C0, 8'h03, 1'b0);
    send_word(rrip_pkg::FUNC_UPDATE, 11'd5, 4'd3, 16'd0, 48'h1080, 8'h03, 1'b0);
    send_word(rrip_pkg::FUNC_UPDATE, 11'd5, 4'd3, 16'd0, 48'h1081, 8'h03, 1'b1);
    send_word(rrip_pkg::FUNC_UPDATE, 11'h7FF, 4'hF, 16'hFFFF, '1, 8'hFF, 1'b1);
    send_word(rrip_pkg::FUNC_UPDATE, 11'h7FF, 4'hF, 16'hFFFF, 48'hFFFF_FFFF_FFBF, 8'hFF, 1'b0);
    send_word(rrip_pkg::FUNC_VICTIM, 11'd5, 4'd0, 16'hFFFF, 48'd0, 8'd0, 1'b0);
    send_word(rrip_pkg::FUNC_VICTIM, 11'h7FF, 4'd0, 16'hFFFF, 48'd0, 8'd0, 1'b0);
    wait_idle();

    write_reg(rrip_pkg::REG_SWEEP_INTERVAL, 20'hFFFFF);
    write_reg(rrip_pkg::REG_STREAM_THRESHOLD, 2'd0);
    write_reg(rrip_pkg::REG_DEAD_THRESHOLD, 2'd3);
    write_reg(rrip_pkg::REG_REUSE_THRESHOLD, 2'd3);
    send_idle_pct = 25; recv_idle_pct = 46;
    repeat (500) random_word();

    // long receiver hold-off while the sender keeps offering words
    hold_off = 1;
    fork
      begin
        repeat (300) @(negedge clk);
        hold_off = 0;
      end
      repeat (20) random_word();
    join
    wait_idle();   // sender pause until everything has drained

    write_reg(rrip_pkg::REG_SWEEP_INTERVAL, 20'd40);
    write_reg(rrip_pkg::REG_STREAM_THRESHOLD, 2'd2);
    write_reg(rrip_pkg::REG_DEAD_THRESHOLD, 2'd1);
    write_reg(rrip_pkg::REG_REUSE_THRESHOLD, 2'd1);
    send_idle_pct = 46; recv_idle_pct = 25;
    repeat (700) random_word();
    wait_idle();

    // lowering the period below the count sweeps on the next update
    write_reg(rrip_pkg::REG_SWEEP_INTERVAL, 20'd3);
    write_reg(rrip_pkg::REG_STREAM_THRESHOLD, 2'd1);
    write_reg(rrip_pkg::REG_DEAD_THRESHOLD, 2'd2);
    write_reg(rrip_pkg::REG_REUSE_THRESHOLD, 2'd2);
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (700) random_word();
    wait_idle();

    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

[sim.f]
rtl/rrip_pkg.sv
rtl/rrip_ship_dead_stream_replacement.sv
test/rrip_checker.sv
test/tb_top.sv
